/* rtl/sitda_pkg.sv */
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned DIGITS_MAX = 10;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned PROD_W    = 2 * VALUE_W;
  localparam int unsigned Q_SHIFT   = 35;
  localparam int unsigned STEP_W    = 3;

  // exact floor(x / 10) for any 32-bit x: (x * RECIP10) >> 35
  localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MUL,
    OP_DIV,
    OP_SIGN,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_MORE,
    COND_LAST
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  rep;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic slot_free;
    logic neg;
    logic more_digits;
    logic last_digit;
  } seq_status_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } seq_cmd_t;

  localparam step_t STEP_LOAD = 3'd0;
  localparam step_t STEP_MUL  = 3'd1;
  localparam step_t STEP_DIV  = 3'd2;
  localparam step_t STEP_SIGN = 3'd3;
  localparam step_t STEP_EMIT = 3'd4;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      STEP_LOAD: w = '{op: OP_LOAD, cond: COND_NEVER, rep: 1'b0, target: STEP_LOAD};
      STEP_MUL:  w = '{op: OP_MUL,  cond: COND_NEVER, rep: 1'b0, target: STEP_LOAD};
      STEP_DIV:  w = '{op: OP_DIV,  cond: COND_MORE,  rep: 1'b0, target: STEP_MUL};
      STEP_SIGN: w = '{op: OP_SIGN, cond: COND_NEVER, rep: 1'b0, target: STEP_LOAD};
      STEP_EMIT: w = '{op: OP_EMIT, cond: COND_LAST,  rep: 1'b1, target: STEP_LOAD};
      default:   w = '{op: OP_LOAD, cond: COND_NEVER, rep: 1'b0, target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* rtl/sitda_seq.sv */
`timescale 1ns / 1ps

module sitda_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sitda_pkg::seq_status_t status,
  output sitda_pkg::seq_cmd_t    cmd
);
  import sitda_pkg::*;

  step_t  pc_r;
  step_t  pc_nxt;
  ucode_t uw;
  logic   done;
  logic   cond_ok;

  assign uw = ucode_rom(pc_r);

  // step completes when its resource is there
  always_comb begin
    case (uw.op)
      OP_LOAD: done = status.in_valid;
      OP_MUL:  done = 1'b1;
      OP_DIV:  done = 1'b1;
      OP_SIGN: done = !status.neg || status.slot_free;
      OP_EMIT: done = status.slot_free;
      default: done = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.cond)
      COND_NEVER: cond_ok = 1'b0;
      COND_MORE:  cond_ok = status.more_digits;
      COND_LAST:  cond_ok = status.last_digit;
      default:    cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (done) begin
      if (cond_ok) begin
        pc_nxt = uw.target;
      end else if (uw.rep) begin
        pc_nxt = pc_r;
      end else begin
        pc_nxt = pc_r + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign cmd.op   = uw.op;
  assign cmd.fire = done;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps

// Converts one signed 32-bit integer per input word into its decimal text, one ASCII
// character per output word, most significant first: a leading '-' for negative
// values, no leading zeros, a single '0' for zero, and out_last high on the final
// character. A small microcode program steps a plain datapath: the input is taken,
// then each digit passes the shared reciprocal multiplier (multiply by 0xCCCCCCCD,
// then quotient and remainder), digits are pushed on a ten-deep stack, and the sign
// and digits leave through a single output register, one per cycle while out_stall
// is low. Only one number is in work at a time; in_stall stays high until its last
// character has been handed to the output register. Nothing is kept from one number
// to the next.

module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_code,
  output logic        out_last
);
  import sitda_pkg::*;

  seq_status_t status;
  seq_cmd_t    cmd;

  // working magnitude and sign
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;

  // digit stack, top of stack (most significant so far) at entry 0
  digit_t dig_r [DIGITS_MAX];
  digit_t dig_nxt [DIGITS_MAX];
  cnt_t   cnt_r, cnt_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_full;
  logic               slot_free;

  // quotient and remainder by ten from the registered product
  assign quot     = VALUE_W'(prod_r[PROD_W-1:Q_SHIFT]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = mag_r - quot_x10;

  assign slot_free = !out_valid_r || !out_stall;

  assign status.in_valid    = in_valid;
  assign status.slot_free   = slot_free;
  assign status.neg         = neg_r;
  assign status.more_digits = (quot != '0) && (cnt_r < cnt_t'(DIGITS_MAX - 1));
  assign status.last_digit  = (cnt_r == cnt_t'(1));

  sitda_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  assign in_stall = (cmd.op != OP_LOAD);

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    cnt_nxt       = cnt_r;
    dig_nxt       = dig_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.fire) begin
      case (cmd.op)
        OP_LOAD: begin
          // magnitude at 32 bits unsigned, so the most negative value is exact
          neg_nxt = in_value[VALUE_W-1];
          mag_nxt = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                         : VALUE_W'(in_value);
          cnt_nxt = '0;
        end
        OP_MUL: begin
          prod_nxt = {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP10};
        end
        OP_DIV: begin
          dig_nxt[0] = rem_full[DIGIT_W-1:0];
          for (int i = 1; i < DIGITS_MAX; i++) begin
            dig_nxt[i] = dig_r[i-1];
          end
          mag_nxt = quot;
          cnt_nxt = cnt_r + cnt_t'(1);
        end
        OP_SIGN: begin
          if (neg_r) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = ASCII_MINUS;
            out_last_nxt  = 1'b0;
          end
        end
        OP_EMIT: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + CHAR_W'(dig_r[0]);
          out_last_nxt  = (cnt_r == cnt_t'(1));
          for (int i = 0; i < DIGITS_MAX - 1; i++) begin
            dig_nxt[i] = dig_r[i+1];
          end
          dig_nxt[DIGITS_MAX-1] = '0;
          cnt_nxt = cnt_r - cnt_t'(1);
        end
        default: begin
          out_valid_nxt = out_valid_r && out_stall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

/* rtl/sitda_chk.sv */
`timescale 1ns / 1ps

module sitda_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char_code,
  input logic        out_last
);
  import sitda_pkg::*;

  // output register empties on reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // one number at a time: no second word taken right after one
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // only a sign or a digit leaves, and the sign never closes a number
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_code == ASCII_MINUS && !out_last) ||
                   (out_char_code >= ASCII_ZERO && out_char_code <= ASCII_ZERO + 8'd9)))
    else $error("bad output character");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_char_code) && $stable(out_last)))
    else $error("stalled output word changed");

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_sitda_chk (.*);
